### rtl/core/fpa_pkg.sv
// Package for the fixed-point ALU: mode codes, status codes, widths and the
// queue entry type shared by the front end, back end and top level.
package fpa_pkg;
	localparam int FracBits = 8;
	localparam int DataW = 32;
	localparam int DivW = DataW + FracBits;
	localparam int BackSt = DivW + 1;
	localparam int QDepth = 4;
	localparam int QPtrW = $clog2(QDepth);

	typedef enum logic [3:0] {
		MODE_ADD = 4'd0, MODE_SUB = 4'd1, MODE_MUL = 4'd2, MODE_DIV = 4'd3,
		MODE_GT = 4'd4, MODE_LT = 4'd5, MODE_GE = 4'd6, MODE_LE = 4'd7,
		MODE_NE = 4'd8, MODE_EQ = 4'd9, MODE_MIN = 4'd10, MODE_MAX = 4'd11,
		MODE_INC = 4'd12, MODE_TOINT = 4'd13, MODE_FROMINT = 4'd14,
		MODE_NONE = 4'd15
	} mode_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	// Classified operation carried from front end to back end.
	typedef struct packed {
		mode_t mode;
		logic signed [DataW-1:0] a;
		logic signed [DataW-1:0] b;
		logic is_div;
		logic neg_q;
		logic [DataW-1:0] mag_a;
		logic [DataW-1:0] mag_b;
	} op_t;

	// Saturate a signed value of width DataW+2 to DataW bits.
	function automatic logic [DataW+1:0] sat_w(input logic signed [DataW+1:0] v);
		logic [DataW+1:0] r;
		r = {2'b00, v[DataW-1:0]};
		if (v > $signed({3'b000, {(DataW-1){1'b1}}}))
			r = {2'b10, 1'b0, {(DataW-1){1'b1}}};
		else if (v < -$signed({3'b001, {(DataW-1){1'b0}}}))
			r = {2'b10, 1'b1, {(DataW-1){1'b0}}};
		return r;
	endfunction
endpackage

### rtl/core/fpa_front.sv
// Front end of the fixed-point ALU: accepts beats and classifies them.
// Depends on fpa_pkg.
module fpa_front
	import fpa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic ready,
	input logic [3:0] mode,
	input logic signed [DataW-1:0] operand_a,
	input logic signed [DataW-1:0] operand_b,
	output logic op_valid,
	input logic op_ready,
	output op_t op
);
	logic vld_q;
	op_t op_q;

	assign ready = !vld_q || op_ready;
	assign op_valid = vld_q;
	assign op = op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ready) begin
			vld_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) begin
			op_q.mode <= mode_t'(mode);
			op_q.a <= operand_a;
			op_q.b <= operand_b;
			op_q.is_div <= (mode_t'(mode) == MODE_DIV) && (operand_b != '0);
			op_q.neg_q <= operand_a[DataW-1] ^ operand_b[DataW-1];
			op_q.mag_a <= operand_a[DataW-1] ? DataW'(-operand_a) : DataW'(operand_a);
			op_q.mag_b <= operand_b[DataW-1] ? DataW'(-operand_b) : DataW'(operand_b);
		end
	end
endmodule

### rtl/core/fpa_queue.sv
// Short queue between front and back ends of the fixed-point ALU.
// Depends on fpa_pkg.
module fpa_queue
	import fpa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input op_t in_op,
	output logic out_valid,
	input logic out_ready,
	output op_t out_op
);
	op_t mem_q [QDepth];
	logic [QPtrW-1:0] wp_q, rp_q;
	logic [QPtrW:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != (QPtrW+1)'(QDepth);
	assign out_valid = cnt_q != '0;
	assign out_op = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {{QPtrW{1'b0}}, push} - {{QPtrW{1'b0}}, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_op;
	end
endmodule

### rtl/core/fpa_back.sv
// Back end of the fixed-point ALU: a pipeline that carries out each operation.
// Stage 0 multiplies, stages 1..DivW divide one quotient bit each,
// the output register takes the rounded, saturated result. Depends on fpa_pkg.
module fpa_back
	import fpa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic op_valid,
	output logic op_ready,
	input op_t op,
	output logic valid,
	input logic ready,
	output logic signed [DataW-1:0] result,
	output logic compare_true,
	output logic [1:0] status
);
	typedef struct packed {
		mode_t mode;
		logic signed [DataW-1:0] a;
		logic signed [DataW-1:0] b;
		logic is_div;
		logic neg_q;
		logic [2*DataW-1:0] prod;
		logic [DivW-1:0] num;
		logic [DataW-1:0] den;
		logic [DataW:0] rem;
		logic [DivW-1:0] quo;
	} st_t;

	st_t st_q [BackSt];
	logic [BackSt-1:0] vld_q;
	logic adv;
	logic out_vld_q;
	logic signed [DataW-1:0] res_q;
	logic cmp_q;
	logic [1:0] stat_q;

	assign adv = !out_vld_q || ready;
	assign op_ready = adv;
	assign valid = out_vld_q;
	assign result = res_q;
	assign compare_true = cmp_q;
	assign status = stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[BackSt-2:0], op_valid};
		end
	end

	// stage 0: multiply and load divider
	always_ff @(posedge clk) begin
		if (adv) begin
			st_q[0].mode <= op.mode;
			st_q[0].a <= op.a;
			st_q[0].b <= op.b;
			st_q[0].is_div <= op.is_div;
			st_q[0].neg_q <= op.neg_q;
			st_q[0].prod <= (2*DataW)'(op.mag_a) * (2*DataW)'(op.mag_b);
			st_q[0].num <= {op.mag_a, {FracBits{1'b0}}};
			st_q[0].den <= op.mag_b;
			st_q[0].rem <= '0;
			st_q[0].quo <= '0;
		end
	end

	// restoring divider, one bit per stage
	for (genvar g = 1; g <= DivW; g++) begin : g_div
		logic [DataW:0] trial;
		logic [DataW+1:0] diff;
		st_t nxt;
		assign trial = {st_q[g-1].rem[DataW-1:0], st_q[g-1].num[DivW-g]};
		assign diff = {1'b0, trial} - {2'b00, st_q[g-1].den};
		always_comb begin
			nxt = st_q[g-1];
			nxt.rem = diff[DataW+1] ? trial : diff[DataW:0];
			nxt.quo[DivW-g] = !diff[DataW+1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_q[g] <= nxt;
			end
		end
	end

	// final round and mux stage input
	st_t f;
	logic [2*DataW-1:0] mq;
	logic [DivW:0] dq;
	logic signed [DataW+1:0] mv, dv, wv;
	logic [DataW+1:0] s;
	logic [DataW-1:0] ai;
	logic signed [DataW-1:0] r_d;
	logic c_d;
	logic [1:0] st_d;

	always_comb begin
		f = st_q[DivW];
		mq = (f.prod + ((2*DataW)'(1) << FracBits >> 1)) >> FracBits;
		// round up when twice the remainder reaches the divisor
		dq = {1'b0, f.quo} + (DivW+1)'({f.rem, 1'b0} >= {2'b00, f.den});
		if (mq > (2*DataW)'(64'h80000000)) mv = {2'b01, {DataW{1'b0}}};
		else mv = (DataW+2)'(mq);
		if (dq > (DivW+1)'(64'h80000000)) dv = {2'b01, {DataW{1'b0}}};
		else dv = (DataW+2)'(dq);
		if (f.neg_q) begin
			mv = -mv;
			dv = -dv;
		end
		ai = DataW'(f.a >>> FracBits);
		r_d = '0;
		c_d = 1'b0;
		st_d = ST_OK;
		wv = '0;
		unique case (f.mode)
			MODE_ADD: wv = (DataW+2)'(f.a) + (DataW+2)'(f.b);
			MODE_SUB: wv = (DataW+2)'(f.a) - (DataW+2)'(f.b);
			MODE_MUL: wv = (f.prod == '0) ? '0 : mv;
			MODE_DIV: wv = dv;
			MODE_INC: wv = (DataW+2)'(f.a) + (DataW+2)'(1);
			MODE_FROMINT: wv = ((f.a >= 0) && (f.a >> (DataW-1-FracBits)) != 0)
				? {2'b01, {DataW{1'b0}}}
				: ((f.a < 0) && (f.a >>> (DataW-1-FracBits)) != -1)
				? {2'b10, {DataW{1'b0}}} : (DataW+2)'(f.a) <<< FracBits;
			default: wv = '0;
		endcase
		s = sat_w(wv);
		unique case (f.mode) inside
			MODE_ADD, MODE_SUB, MODE_MUL, MODE_INC, MODE_FROMINT: begin
				r_d = s[DataW-1:0];
				st_d = s[DataW+1] ? ST_OVF : ST_OK;
			end
			MODE_DIV: begin
				if (!f.is_div) begin
					r_d = f.a[DataW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
					st_d = ST_DIVZ;
				end else begin
					r_d = s[DataW-1:0];
					st_d = s[DataW+1] ? ST_OVF : ST_OK;
				end
			end
			MODE_GT: c_d = f.a > f.b;
			MODE_LT: c_d = f.a < f.b;
			MODE_GE: c_d = f.a >= f.b;
			MODE_LE: c_d = f.a <= f.b;
			MODE_NE: c_d = f.a != f.b;
			MODE_EQ: c_d = f.a == f.b;
			MODE_MIN: r_d = (f.a < f.b) ? f.a : f.b;
			MODE_MAX: r_d = (f.a > f.b) ? f.a : f.b;
			MODE_TOINT: r_d = ai;
			default: r_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_q[BackSt-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= r_d;
			cmp_q <= c_d;
			stat_q <= st_d;
		end
	end
endmodule

### rtl/core/fixed_point_alu_top.sv
// Signed Q24.8 fixed-point ALU: add, sub, mul, div, compare, min/max, inc and
// integer conversion, with round-half-away and saturation. One beat per cycle
// is accepted while the output is not held; each result passes through the input register,
// one queue slot, the multiply stage, the DivW bit-per-stage divider stages that
// every operation passes through, and the output register. A held output
// freezes the whole back end; the four-entry queue and the input register then
// take further beats before the input stalls.
// Depends on fpa_pkg, fpa_front, fpa_queue, fpa_back.
module fixed_point_alu_top
	import fpa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [3:0] mode,
	input logic signed [DataW-1:0] operand_a,
	input logic signed [DataW-1:0] operand_b,
	output logic out_valid,
	input logic out_ready,
	output logic signed [DataW-1:0] result,
	output logic compare_true,
	output logic [1:0] status
);
	logic f_vld, f_rdy, b_vld, b_rdy;
	op_t f_op, b_op;

	fpa_front u_front (.clk, .arst_n, .valid(in_valid), .ready(in_ready), .mode,
		.operand_a, .operand_b, .op_valid(f_vld), .op_ready(f_rdy), .op(f_op));

	fpa_queue u_queue (.clk, .arst_n, .in_valid(f_vld), .in_ready(f_rdy), .in_op(f_op),
		.out_valid(b_vld), .out_ready(b_rdy), .out_op(b_op));

	fpa_back u_back (.clk, .arst_n, .op_valid(b_vld), .op_ready(b_rdy), .op(b_op),
		.valid(out_valid), .ready(out_ready), .result, .compare_true, .status);
endmodule

### verif/fixed_point_alu_top_tb.sv
// Testbench for fixed_point_alu_top: directed table then random beats, each result
// checked against the table or a Q24.8 bench model. Depends on fpa_pkg and the RTL.
`timescale 1ns / 100ps
module fixed_point_alu_top_tb
	import fpa_pkg::*;
();

	localparam int NumRandom = 1625;
	localparam int IdleLimit = 20000;
	localparam int Latency = 60;
	localparam int HoldStart = 300;
	localparam int HoldCycles = 600;

	typedef struct {
		logic [3:0] mode;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} op_beat_t;

	typedef struct {
		logic signed [31:0] res;
		logic cmp;
		logic [1:0] st;
	} alu_out_t;

	typedef struct {
		op_beat_t op;
		bit known;
		alu_out_t want;
	} table_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [3:0] mode;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] result;
	logic compare_true;
	logic [1:0] status;

	alu_out_t pending_results[$];
	int mismatch_cnt;
	int idle_cycles;
	int sent_cnt;
	bit send_done;
	bit hold_off;

	fixed_point_alu_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.result(result), .compare_true(compare_true), .status(status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic alu_out_t sat_to_word(logic signed [65:0] v);
		alu_out_t o;
		o = '{res: v[31:0], cmp: 1'b0, st: ST_OK};
		if (v > 66'sd2147483647) begin
			o.res = 32'h7FFFFFFF;
			o.st = ST_OVF;
		end else if (v < -66'sd2147483648) begin
			o.res = 32'h80000000;
			o.st = ST_OVF;
		end
		return o;
	endfunction

	function automatic alu_out_t alu_predict(op_beat_t op);
		alu_out_t o;
		logic signed [65:0] a, b, p, v;
		logic [65:0] mag, num, den, q, r;
		bit neg;
		a = op.a;
		b = op.b;
		o = '{res: '0, cmp: 1'b0, st: ST_OK};
		case (op.mode)
			MODE_ADD: o = sat_to_word(a + b);
			MODE_SUB: o = sat_to_word(a - b);
			MODE_MUL: begin
				p = a * b;
				mag = p < 0 ? -p : p;
				q = (mag + (66'd1 << (FracBits - 1))) >> FracBits;
				v = q;
				o = sat_to_word(p < 0 ? -v : v);
			end
			MODE_DIV: begin
				if (b == 0) begin
					o.res = a < 0 ? 32'h80000000 : 32'h7FFFFFFF;
					o.st = ST_DIVZ;
				end else begin
					num = (a < 0 ? -a : a) << FracBits;
					den = b < 0 ? -b : b;
					q = num / den;
					r = num % den;
					if (2 * r >= den)
						q = q + 1;
					neg = (a < 0) != (b < 0);
					v = q;
					o = sat_to_word(neg ? -v : v);
				end
			end
			MODE_GT: o.cmp = a > b;
			MODE_LT: o.cmp = a < b;
			MODE_GE: o.cmp = a >= b;
			MODE_LE: o.cmp = a <= b;
			MODE_NE: o.cmp = a != b;
			MODE_EQ: o.cmp = a == b;
			MODE_MIN: o.res = a < b ? op.a : op.b;
			MODE_MAX: o.res = a > b ? op.a : op.b;
			MODE_INC: o = sat_to_word(a + 1);
			MODE_TOINT: o.res = op.a >>> FracBits;
			MODE_FROMINT: o = sat_to_word(a * (66'sd1 <<< FracBits));
			default: ;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatch_cnt++;
	endtask

	// start at a falling edge; return at the falling edge after the beat is taken
	task automatic send_beat(op_beat_t op, bit known, alu_out_t want);
		int gap;
		gap = $urandom_range(0, 19);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= op.mode;
		operand_a <= op.a;
		operand_b <= op.b;
		pending_results.push_back(known ? want : alu_predict(op));
		sent_cnt++;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF - $urandom_range(0, 2);
			1: return 32'h80000000 + $urandom_range(0, 2);
			2: return $signed($urandom_range(0, 1024)) - 512;
			3: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
			default: return $urandom;
		endcase
	endfunction

	// stimulus
	initial begin
		table_row_t dir_tbl[$];
		op_beat_t op;
		alu_out_t none;
		none = '{res: '0, cmp: 1'b0, st: ST_OK};
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_ADD;
		operand_a = '0;
		operand_b = '0;
		send_done = 1'b0;
		sent_cnt = 0;
		dir_tbl = '{
			'{'{MODE_ADD, 32'sh7FFFFFFF, 32'sd1}, 1, '{32'h7FFFFFFF, 1'b0, ST_OVF}},
			'{'{MODE_ADD, 32'sh80000000, -32'sd1}, 1, '{32'h80000000, 1'b0, ST_OVF}},
			'{'{MODE_SUB, 32'sh80000000, 32'sd1}, 1, '{32'h80000000, 1'b0, ST_OVF}},
			'{'{MODE_SUB, 32'sd5, 32'sd7}, 1, '{-32'sd2, 1'b0, ST_OK}},
			'{'{MODE_MUL, 32'sd256, 32'sd256}, 1, '{32'sd256, 1'b0, ST_OK}},
			'{'{MODE_MUL, 32'sd1, 32'sd128}, 1, '{32'sd1, 1'b0, ST_OK}},
			'{'{MODE_MUL, -32'sd1, 32'sd128}, 1, '{-32'sd1, 1'b0, ST_OK}},
			'{'{MODE_MUL, 32'sh80000000, 32'sh80000000}, 1, '{32'h7FFFFFFF, 1'b0, ST_OVF}},
			'{'{MODE_MUL, 32'sh7FFFFFFF, 32'sh80000000}, 1, '{32'h80000000, 1'b0, ST_OVF}},
			'{'{MODE_DIV, 32'sd5, 32'sd0}, 1, '{32'h7FFFFFFF, 1'b0, ST_DIVZ}},
			'{'{MODE_DIV, -32'sd5, 32'sd0}, 1, '{32'h80000000, 1'b0, ST_DIVZ}},
			'{'{MODE_DIV, 32'sd0, 32'sd0}, 1, '{32'h7FFFFFFF, 1'b0, ST_DIVZ}},
			'{'{MODE_DIV, 32'sh80000000, 32'sd1}, 1, '{32'h80000000, 1'b0, ST_OVF}},
			'{'{MODE_DIV, 32'sd1, -32'sd512}, 0, none},
			'{'{MODE_GT, 32'sh7FFFFFFF, 32'sh80000000}, 1, '{32'sd0, 1'b1, ST_OK}},
			'{'{MODE_LT, 32'sh7FFFFFFF, 32'sh80000000}, 1, '{32'sd0, 1'b0, ST_OK}},
			'{'{MODE_GE, 32'sd3, 32'sd3}, 1, '{32'sd0, 1'b1, ST_OK}},
			'{'{MODE_LE, 32'sd4, 32'sd3}, 1, '{32'sd0, 1'b0, ST_OK}},
			'{'{MODE_NE, 32'sd3, 32'sd3}, 1, '{32'sd0, 1'b0, ST_OK}},
			'{'{MODE_EQ, 32'sh80000000, 32'sh80000000}, 1, '{32'sd0, 1'b1, ST_OK}},
			'{'{MODE_MIN, 32'sh80000000, 32'sh7FFFFFFF}, 1, '{32'h80000000, 1'b0, ST_OK}},
			'{'{MODE_MAX, 32'sh80000000, 32'sh7FFFFFFF}, 1, '{32'h7FFFFFFF, 1'b0, ST_OK}},
			'{'{MODE_INC, 32'sh7FFFFFFF, 32'sd0}, 1, '{32'h7FFFFFFF, 1'b0, ST_OVF}},
			'{'{MODE_TOINT, -32'sd1, 32'sd0}, 1, '{-32'sd1, 1'b0, ST_OK}},
			'{'{MODE_FROMINT, 32'sh00800000, 32'sd0}, 1, '{32'h7FFFFFFF, 1'b0, ST_OVF}},
			'{'{MODE_NONE, 32'sh7FFFFFFF, 32'shFFFFFFFF}, 1, none}
		};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (dir_tbl[i])
			send_beat(dir_tbl[i].op, dir_tbl[i].known, dir_tbl[i].want);
		for (int n = 0; n < NumRandom; n++) begin
			op.mode = 4'($urandom_range(0, 15));
			op.a = rand_word();
			op.b = ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_word();
			if (op.mode == MODE_FROMINT && $urandom_range(0, 1))
				op.a = $signed($urandom_range(0, 32'hFFFFFF)) - 32'sh800000;
			send_beat(op, 0, none);
		end
		in_valid <= 1'b0;
		send_done = 1'b1;
	end

	// receiver, with one long hold-off to back the pipeline up
	initial begin
		int gap;
		out_ready = 1'b0;
		hold_off = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
			if ($urandom_range(0, 1))
				gap = 0;
			if (!hold_off && sent_cnt >= HoldStart) begin
				hold_off = 1'b1;
				gap = HoldCycles;
			end
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// check each result beat against the oldest prediction
	always @(posedge clk) begin
		alu_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", result, '0);
			end else begin
				want = pending_results.pop_front();
				if (result !== want.res)
					report_mismatch("result", result, want.res);
				if (compare_true !== want.cmp)
					report_mismatch("compare_true", compare_true, want.cmp);
				if (status !== want.st)
					report_mismatch("status", status, want.st);
			end
		end
	end

	// watchdog and end of run
	initial begin
		mismatch_cnt = 0;
		idle_cycles = 0;
		@(posedge arst_n);
		while (!(send_done && pending_results.size() == 0) && idle_cycles < IdleLimit) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		if (idle_cycles >= IdleLimit) begin
			$display("fixed_point_alu_top_tb: done, errors");
		end else begin
			repeat (Latency) @(posedge clk);
			if (mismatch_cnt == 0)
				$display("fixed_point_alu_top_tb: done, clean");
			else
				$display("fixed_point_alu_top_tb: done, errors");
		end
		$finish;
	end
endmodule

### fixed_point_alu_top.f
rtl/core/fpa_pkg.sv
rtl/core/fpa_front.sv
rtl/core/fpa_queue.sv
rtl/core/fpa_back.sv
rtl/core/fixed_point_alu_top.sv
verif/fixed_point_alu_top_tb.sv
